// File: rtl/mma_pkg.sv
// ----------------------------------------------------------------------------
// mma_pkg
// Shared types and codes of the matrix multiply accumulate engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mma_pkg;

  localparam int REQ_W    = 3;
  localparam int IDX_W    = 4;
  localparam int VAL_W    = 16;
  localparam int DIMCFG_W = 5;
  localparam int SCALE_W  = 16;
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;
  localparam int REGIDX_W = 3;

  // request codes
  localparam logic [REQ_W-1:0] REQ_WR_A    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_WR_B    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_WR_C    = 3'd2;
  localparam logic [REQ_W-1:0] REQ_COMPUTE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_RD_C    = 3'd4;

  // register indexes, byte address is 4 * index
  localparam logic [REGIDX_W-1:0] REG_ROWS_M  = 3'd0;
  localparam logic [REGIDX_W-1:0] REG_INNER_K = 3'd1;
  localparam logic [REGIDX_W-1:0] REG_COLS_N  = 3'd2;
  localparam logic [REGIDX_W-1:0] REG_ALPHA   = 3'd3;
  localparam logic [REGIDX_W-1:0] REG_BETA    = 3'd4;

  typedef struct packed {
    logic [DIMCFG_W-1:0]       rows_m;
    logic [DIMCFG_W-1:0]       inner_k;
    logic [DIMCFG_W-1:0]       cols_n;
    logic signed [SCALE_W-1:0] alpha_scale;
    logic signed [SCALE_W-1:0] beta_scale;
  } cfg_t;

  // controller to datapath
  typedef struct packed {
    logic in_ready;
    logic acc_item;
    logic clr_wr;
    logic cmp_init;
    logic elem_start;
    logic dot_issue;
    logic scale_issue;
    logic elem_write;
    logic rd_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_valid;
    logic is_read;
    logic is_compute;
    logic out_full;
    logic clr_last;
    logic j_last;
    logic dg_last;
    logic c_last;
    logic r_last;
    logic mn_zero;
    logic k_zero;
    logic dot_busy;
    logic sc_busy;
  } sts_t;

endpackage

`default_nettype wire

// File: rtl/mma_req_if.sv
// ----------------------------------------------------------------------------
// mma_req_if
// Request channel: element loads, compute start and reads of C.
// ----------------------------------------------------------------------------
`default_nettype none

interface mma_req_if;
  logic               valid;
  logic               ready;
  logic [2:0]         req_type;
  logic [3:0]         row_index;
  logic [3:0]         col_index;
  logic signed [15:0] element_value;

  modport source (
    output valid, req_type, row_index, col_index, element_value,
    input  ready
  );
  modport sink (
    input  valid, req_type, row_index, col_index, element_value,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/mma_rsp_if.sv
// ----------------------------------------------------------------------------
// mma_rsp_if
// Response channel: one item for each read of C.
// ----------------------------------------------------------------------------
`default_nettype none

interface mma_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] read_value;
  logic               saturated;

  modport source (
    output valid, read_value, saturated,
    input  ready
  );
  modport sink (
    input  valid, read_value, saturated,
    output ready
  );
endinterface

`default_nettype wire

// File: rtl/mma_cfg.sv
// ----------------------------------------------------------------------------
// mma_cfg
// APB register file holding the matrix shape and the two Q8.8 scales.
// ----------------------------------------------------------------------------
`default_nettype none

module mma_cfg import mma_pkg::*; (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire [PADDR_W-1:0]   paddr,
  input  wire [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t                cfg_q;
  logic [REGIDX_W-1:0] reg_idx;
  logic                wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rows_m      <= DIMCFG_W'(16);
      cfg_q.inner_k     <= DIMCFG_W'(16);
      cfg_q.cols_n      <= DIMCFG_W'(16);
      cfg_q.alpha_scale <= SCALE_W'(256);
      cfg_q.beta_scale  <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_ROWS_M:  cfg_q.rows_m      <= pwdata[DIMCFG_W-1:0];
        REG_INNER_K: cfg_q.inner_k     <= pwdata[DIMCFG_W-1:0];
        REG_COLS_N:  cfg_q.cols_n      <= pwdata[DIMCFG_W-1:0];
        REG_ALPHA:   cfg_q.alpha_scale <= signed'(pwdata[SCALE_W-1:0]);
        REG_BETA:    cfg_q.beta_scale  <= signed'(pwdata[SCALE_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_ROWS_M:  prdata = PDATA_W'(cfg_q.rows_m);
      REG_INNER_K: prdata = PDATA_W'(cfg_q.inner_k);
      REG_COLS_N:  prdata = PDATA_W'(cfg_q.cols_n);
      REG_ALPHA:   prdata = PDATA_W'(unsigned'(cfg_q.alpha_scale));
      REG_BETA:    prdata = PDATA_W'(unsigned'(cfg_q.beta_scale));
      default:     prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: rtl/mma_ctrl.sv
// ----------------------------------------------------------------------------
// mma_ctrl
// Sequencer: clearing pass, item intake, and the element loop of a compute.
// ----------------------------------------------------------------------------
`default_nettype none

module mma_ctrl import mma_pkg::*; (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  sts_t  sts_i,
  output cmd_t  cmd_o
);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_START = 3'd3;
  localparam logic [2:0] ST_DOT   = 3'd4;
  localparam logic [2:0] ST_SCALE = 3'd5;
  localparam logic [2:0] ST_WRITE = 3'd6;

  logic [2:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clr_wr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        // a read waits only if the output register stays occupied
        cmd_o.in_ready = !(sts_i.is_read && sts_i.out_full);
        cmd_o.acc_item = cmd_o.in_ready && sts_i.in_valid;
        if (cmd_o.acc_item) begin
          if (sts_i.is_compute) begin
            cmd_o.cmp_init = 1'b1;
            if (!sts_i.mn_zero) begin
              state_d = ST_START;
            end
          end else if (sts_i.is_read) begin
            state_d = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd_o.rd_load = 1'b1;
        state_d       = ST_IDLE;
      end
      ST_START: begin
        cmd_o.elem_start = 1'b1;
        state_d          = sts_i.k_zero ? ST_SCALE : ST_DOT;
      end
      ST_DOT: begin
        cmd_o.dot_issue = 1'b1;
        if (sts_i.j_last) begin
          state_d = ST_SCALE;
        end
      end
      ST_SCALE: begin
        // digits go out once the dot product has drained
        if (!sts_i.dot_busy) begin
          cmd_o.scale_issue = 1'b1;
          if (sts_i.dg_last) begin
            state_d = ST_WRITE;
          end
        end
      end
      ST_WRITE: begin
        if (!sts_i.sc_busy) begin
          cmd_o.elem_write = 1'b1;
          state_d = (sts_i.r_last && sts_i.c_last) ? ST_IDLE : ST_START;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/mma_dp.sv
// ----------------------------------------------------------------------------
// mma_dp
// Datapath: A, B and C memories, element counters, dot product pipeline,
// digit-serial alpha scaling, beta scaling, saturation and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mma_dp import mma_pkg::*; #(
  parameter int MAX_DIM    = 16,
  parameter int ELEM_WIDTH = 16
) (
  input  wire   clk_i,
  input  wire   rst_ni,
  input  cfg_t  cfg_i,
  input  cmd_t  cmd_i,
  output sts_t  sts_o,
  mma_req_if.sink   req,
  mma_rsp_if.source rsp
);

  localparam int EW    = ELEM_WIDTH;
  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = $clog2(MAX_DIM);
  localparam int LW    = $clog2(MAX_DIM + 1);
  localparam int SW    = 2 * EW + DW + 1;     // exact dot product width
  localparam int ND    = (SW + 15) / 16;      // 16-bit digits of the dot product
  localparam int SXW   = ND * 16;
  localparam int PW    = SXW + 16;            // alpha times dot product
  localparam int VW    = SXW + 1;             // pre-saturation sum
  localparam int DGW   = $clog2(ND);
  localparam int BW    = EW + SCALE_W;

  localparam logic [AW-1:0]        DIM_A  = AW'(MAX_DIM);
  localparam logic [AW-1:0]        LAST_A = AW'(DEPTH - 1);
  localparam logic [DGW-1:0]       DG_TOP = DGW'(ND - 1);
  localparam logic signed [VW-1:0] V_HI   = (VW'(1) << (EW - 1)) - VW'(1);
  localparam logic signed [VW-1:0] V_LO   = ~V_HI;
  localparam logic signed [EW-1:0] E_HI   = {1'b0, {(EW-1){1'b1}}};
  localparam logic signed [EW-1:0] E_LO   = {1'b1, {(EW-1){1'b0}}};

  logic signed [EW-1:0] a_mem [DEPTH];
  logic signed [EW-1:0] b_mem [DEPTH];
  logic signed [EW-1:0] c_mem [DEPTH];

  logic [DW-1:0]  r_q, c_q, j_q;
  logic [DGW-1:0] dg_q;
  logic [AW-1:0]  clr_q;
  logic [LW-1:0]  mlim, klim, nlim;

  logic [DW-1:0]        in_row, in_col;
  logic                 in_range;
  logic [AW-1:0]        in_addr, el_addr, a_addr, b_addr;
  logic signed [EW-1:0] in_val;
  logic                 wr_a, wr_b, wr_c, rd_acc;

  logic                 c_we, c_re;
  logic [AW-1:0]        c_waddr, c_raddr;
  logic signed [EW-1:0] c_wdata;

  logic signed [EW-1:0]   a_rd_q, b_rd_q, c_rd_q;
  logic                   rd_vld_q, prod_vld_q, sc_vld_q;
  logic signed [2*EW-1:0] prod_q;
  logic signed [SW-1:0]   acc_q;
  logic signed [SXW-1:0]  acc_sx;
  logic [15:0]            dig_raw;
  logic signed [16:0]     dig;
  logic signed [32:0]     sprod_q;
  logic signed [PW-1:0]   pacc_q;
  logic signed [BW-1:0]   bprod_q;

  logic signed [SXW-1:0]  a_part;
  logic signed [EW+7:0]   b_part;
  logic signed [VW-1:0]   v_sum;
  logic signed [EW-1:0]   res;
  logic                   res_sat;

  logic                   sat_q, rd_inr_q;
  logic                   out_vld_q, out_sat_q;
  logic signed [15:0]     out_val_q;

  // shape limits, sizes above the array saturate
  assign mlim = (32'(cfg_i.rows_m)  > MAX_DIM) ? LW'(MAX_DIM) : LW'(cfg_i.rows_m);
  assign klim = (32'(cfg_i.inner_k) > MAX_DIM) ? LW'(MAX_DIM) : LW'(cfg_i.inner_k);
  assign nlim = (32'(cfg_i.cols_n)  > MAX_DIM) ? LW'(MAX_DIM) : LW'(cfg_i.cols_n);

  // input decode
  assign in_row   = DW'(req.row_index);
  assign in_col   = DW'(req.col_index);
  assign in_range = (32'(req.row_index) < MAX_DIM) && (32'(req.col_index) < MAX_DIM);
  assign in_addr  = AW'(in_row) * DIM_A + AW'(in_col);
  assign in_val   = EW'(req.element_value);
  assign wr_a     = cmd_i.acc_item && (req.req_type == REQ_WR_A) && in_range;
  assign wr_b     = cmd_i.acc_item && (req.req_type == REQ_WR_B) && in_range;
  assign wr_c     = cmd_i.acc_item && (req.req_type == REQ_WR_C) && in_range;
  assign rd_acc   = cmd_i.acc_item && (req.req_type == REQ_RD_C);

  assign el_addr = AW'(r_q) * DIM_A + AW'(c_q);
  assign a_addr  = AW'(r_q) * DIM_A + AW'(j_q);
  assign b_addr  = AW'(j_q) * DIM_A + AW'(c_q);

  // element counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q   <= '0;
      c_q   <= '0;
      j_q   <= '0;
      dg_q  <= '0;
      clr_q <= '0;
    end else begin
      if (cmd_i.clr_wr) begin
        clr_q <= clr_q + AW'(1);
      end
      if (cmd_i.cmp_init) begin
        r_q <= '0;
        c_q <= '0;
      end
      if (cmd_i.elem_start) begin
        j_q  <= '0;
        dg_q <= DG_TOP;
      end
      if (cmd_i.dot_issue) begin
        j_q <= j_q + DW'(1);
      end
      if (cmd_i.scale_issue) begin
        dg_q <= dg_q - DGW'(1);
      end
      if (cmd_i.elem_write) begin
        if (sts_o.c_last) begin
          c_q <= '0;
          r_q <= r_q + DW'(1);
        end else begin
          c_q <= c_q + DW'(1);
        end
      end
    end
  end

  // A and B memories
  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      a_mem[in_addr] <= in_val;
    end
    if (cmd_i.dot_issue) begin
      a_rd_q <= a_mem[a_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) begin
      b_mem[in_addr] <= in_val;
    end
    if (cmd_i.dot_issue) begin
      b_rd_q <= b_mem[b_addr];
    end
  end

  // C memory port selection
  always_comb begin
    c_we    = 1'b0;
    c_waddr = in_addr;
    c_wdata = in_val;
    if (cmd_i.clr_wr) begin
      c_we    = 1'b1;
      c_waddr = clr_q;
      c_wdata = '0;
    end else if (cmd_i.elem_write) begin
      c_we    = 1'b1;
      c_waddr = el_addr;
      c_wdata = res;
    end else if (wr_c) begin
      c_we = 1'b1;
    end
  end

  assign c_re    = cmd_i.elem_start || rd_acc;
  assign c_raddr = cmd_i.elem_start ? el_addr : in_addr;

  always_ff @(posedge clk_i) begin
    if (c_we) begin
      c_mem[c_waddr] <= c_wdata;
    end
    if (c_re) begin
      c_rd_q <= c_mem[c_raddr];
    end
  end

  // pipeline valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
      sc_vld_q   <= 1'b0;
    end else begin
      rd_vld_q   <= cmd_i.dot_issue;
      prod_vld_q <= rd_vld_q;
      sc_vld_q   <= cmd_i.scale_issue;
    end
  end

  // dot product: read, multiply, accumulate
  always_ff @(posedge clk_i) begin
    prod_q <= a_rd_q * b_rd_q;
    if (cmd_i.elem_start) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + SW'(prod_q);
    end
  end

  // alpha scaling, top digit first, signed top digit and unsigned lower ones
  assign acc_sx  = SXW'(acc_q);
  assign dig_raw = acc_sx[16*dg_q +: 16];
  assign dig     = (dg_q == DG_TOP) ? {dig_raw[15], dig_raw} : {1'b0, dig_raw};

  always_ff @(posedge clk_i) begin
    sprod_q <= cfg_i.alpha_scale * dig;
    bprod_q <= cfg_i.beta_scale * c_rd_q;
    if (cmd_i.elem_start) begin
      pacc_q <= '0;
    end else if (sc_vld_q) begin
      pacc_q <= (pacc_q <<< 16) + PW'(sprod_q);
    end
  end

  // floor shifts by dropping low bits, then saturate
  assign a_part  = pacc_q[PW-1:16];
  assign b_part  = bprod_q[BW-1:8];
  assign v_sum   = VW'(a_part) + VW'(b_part);
  assign res_sat = (v_sum > V_HI) || (v_sum < V_LO);

  always_comb begin
    if (v_sum > V_HI) begin
      res = E_HI;
    end else if (v_sum < V_LO) begin
      res = E_LO;
    end else begin
      res = v_sum[EW-1:0];
    end
  end

  // saturation flag and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cmd_i.cmp_init) begin
        sat_q <= 1'b0;
      end else if (cmd_i.elem_write && res_sat) begin
        sat_q <= 1'b1;
      end
      if (cmd_i.rd_load) begin
        out_vld_q <= 1'b1;
      end else if (rsp.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_acc) begin
      rd_inr_q <= in_range;
    end
    if (cmd_i.rd_load) begin
      out_val_q <= rd_inr_q ? 16'(c_rd_q) : '0;
      out_sat_q <= sat_q;
    end
  end

  assign req.ready      = cmd_i.in_ready;
  assign rsp.valid      = out_vld_q;
  assign rsp.read_value = out_val_q;
  assign rsp.saturated  = out_sat_q;

  always_comb begin
    sts_o            = '0;
    sts_o.in_valid   = req.valid;
    sts_o.is_read    = (req.req_type == REQ_RD_C);
    sts_o.is_compute = (req.req_type == REQ_COMPUTE);
    sts_o.out_full   = out_vld_q && !rsp.ready;
    sts_o.clr_last   = (clr_q == LAST_A);
    sts_o.j_last     = ((LW'(j_q) + LW'(1)) == klim);
    sts_o.dg_last    = (dg_q == '0);
    sts_o.c_last     = ((LW'(c_q) + LW'(1)) == nlim);
    sts_o.r_last     = ((LW'(r_q) + LW'(1)) == mlim);
    sts_o.mn_zero    = (mlim == '0) || (nlim == '0);
    sts_o.k_zero     = (klim == '0);
    sts_o.dot_busy   = rd_vld_q || prod_vld_q;
    sts_o.sc_busy    = sc_vld_q;
  end

endmodule

`default_nettype wire

// File: rtl/matrix_multiply_accumulate.sv
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate
// Fixed-point GEMM engine, C = alpha*A*B + beta*C, Q8.8 elements.
// ----------------------------------------------------------------------------
// Element writes to A, B and C are taken one per cycle while the engine is
// idle. A read of C goes through the registered C memory read, then the load
// of the output register, and its result item then waits in the output
// register while further writes are taken. A compute runs over every output
// element in turn through one A/B read pair and one multiplier per product,
// then a digit serial alpha scaling with ND digits, no item being taken
// meanwhile; ND = ceil((2*ELEM_WIDTH+clog2(MAX_DIM)+1)/16), 3 at the defaults.
// After reset a clearing pass writes zero into all MAX_DIM*MAX_DIM entries of
// C, one per cycle, during which no item is taken; register writes are taken
// as ever.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_multiply_accumulate import mma_pkg::*; #(
  parameter int MAX_DIM    = 16,
  parameter int ELEM_WIDTH = 16
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  mma_req_if.sink            req,
  mma_rsp_if.source          rsp,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire [PADDR_W-1:0]  paddr,
  input  wire [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  mma_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  mma_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  mma_dp #(
    .MAX_DIM    (MAX_DIM),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .req    (req),
    .rsp    (rsp)
  );

endmodule

`default_nettype wire

// File: bench/matrix_multiply_accumulate_tb.sv
// ----------------------------------------------------------------------------
// matrix_multiply_accumulate_tb
// Self-checking bench for the fixed-point GEMM engine, C = alpha*A*B + beta*C.
// ----------------------------------------------------------------------------
// A short table of directed requests comes first: reads after reset, extreme
// elements, ignored request codes, saturation in both directions, a zero inner
// size and an empty compute. Random phases follow, each with its own shape and
// scales. Each read of C is predicted by a bench model of the engine, or by the
// table for checked rows, and compared field by field with the response. Shapes
// and scales change over APB only once the engine has drained. Both channels
// idle at random, and the response side stalls once for a long stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_multiply_accumulate_tb import mma_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID        = 16;
  localparam int HOLD_AT     = 480;
  localparam int HOLD_CYCLES = 400;

  // request codes the engine ignores
  localparam logic [REQ_W-1:0] REQ_RSVD_5 = 3'd5;
  localparam logic [REQ_W-1:0] REQ_RSVD_6 = 3'd6;
  localparam logic [REQ_W-1:0] REQ_RSVD_7 = 3'd7;

  typedef struct packed {
    logic [REQ_W-1:0]        req;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
  } gemm_req_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    sat;
  } rd_result_t;

  typedef struct {
    bit                      cfg_row;
    logic [2:0]              code;
    logic [IDX_W-1:0]        row;
    logic [IDX_W-1:0]        col;
    logic signed [VAL_W-1:0] value;
    bit                      typed;
    logic signed [VAL_W-1:0] exp_value;
    bit                      exp_sat;
  } directed_row_t;

  localparam bit ITEM = 1'b0;
  localparam bit CFG  = 1'b1;
  localparam bit CHK  = 1'b1;
  localparam bit ANY  = 1'b0;

  localparam int DIR_ROWS = 33;

  directed_row_t dir_tbl [DIR_ROWS] = '{
    '{ITEM, REQ_RD_C,    4'd0,  4'd0,  16'sh0000, CHK, 16'sh0000, 1'b0},
    '{ITEM, REQ_RD_C,    4'd15, 4'd15, 16'sh0000, CHK, 16'sh0000, 1'b0},
    '{ITEM, REQ_WR_C,    4'd3,  4'd4,  16'sh7fff, ANY, 16'sh0000, 1'b0},
    '{ITEM, REQ_RD_C,    4'd3,  4'd4,  16'sh0000, CHK, 16'sh7fff, 1'b0},
    '{ITEM, REQ_WR_C,    4'd15, 4'd15, 16'sh8000, ANY, 16'sh0000, 1'b0},
    '{ITEM, REQ_RD_C,    4'd15, 4'd15, 16'sh0000, CHK, 16'sh8000, 1'b0},
    '{ITEM, REQ_RSVD_5,  4'd7,  4'd9,  16'sh1234, ANY, 16'sh0000, 1'b0},
    '{ITEM, REQ_RSVD_6,  4'd15, 4'd15, 16'shffff, ANY, 16'sh0000, 1'b0},
    '{ITEM, REQ_RSVD_7,  4'd0,  4'd0,  16'sh7fff, ANY, 16'sh0000, 1'b0},
    '{ITEM, REQ_RD_C,    4'd15, 4'd15, 16'sh0000, ANY, 16'sh0000, 1'b0},
    '{CFG,  REG_ROWS_M,  4'd0,  4'd0,  16'sh0001, ANY, 16'sh0000, 1'b0},
    '{CFG,  REG_INNER_K, 4'd0,  4'd0,  16'sh0001, ANY, 16'sh0000, 1'b0},
    '{CFG,  REG_COLS_N,  4'd0,  4'd0,  16'sh0001, ANY, 16'sh0000, 1'b0},
    '{ITEM, REQ_WR_A,    4'd0,  4'd0,  16'sh7fff, ANY, 16'sh0000, 1'b0},
    '{ITEM, REQ_WR_B,    4'd0,  4'd0,  16'sh7fff, ANY, 16'sh0000, 1'b0},
    '{ITEM, REQ_COMPUTE, 4'd0,  4'd0,  16'sh0000, ANY, 16'sh0000, 1'b0},
    '{ITEM, REQ_RD_C,    4'd0,  4'd0,  16'sh0000, CHK, 16'sh7fff, 1'b1},
    '{ITEM, REQ_WR_A,    4'd0,  4'd0,  16'sh8000, ANY, 16'sh0000, 1'b0},
    '{ITEM, REQ_COMPUTE, 4'd9,  4'd2,  16'sh5a5a, ANY, 16'sh0000, 1'b0},
    '{ITEM, REQ_RD_C,    4'd0,  4'd0,  16'sh0000, CHK, 16'sh8000, 1'b1},
    '{ITEM, REQ_RD_C,    4'd3,  4'd4,  16'sh0000, CHK, 16'sh7fff, 1'b1},
    '{CFG,  REG_ALPHA,   4'd0,  4'd0,  16'sh0000, ANY, 16'sh0000, 1'b0},
    '{CFG,  REG_BETA,    4'd0,  4'd0,  16'sh0100, ANY, 16'sh0000, 1'b0},
    '{ITEM, REQ_COMPUTE, 4'd0,  4'd0,  16'sh0000, ANY, 16'sh0000, 1'b0},
    '{ITEM, REQ_RD_C,    4'd0,  4'd0,  16'sh0000, CHK, 16'sh8000, 1'b0},
    '{CFG,  REG_INNER_K, 4'd0,  4'd0,  16'sh0000, ANY, 16'sh0000, 1'b0},
    '{CFG,  REG_ALPHA,   4'd0,  4'd0,  16'sh0100, ANY, 16'sh0000, 1'b0},
    '{CFG,  REG_BETA,    4'd0,  4'd0,  16'shff00, ANY, 16'sh0000, 1'b0},
    '{ITEM, REQ_COMPUTE, 4'd0,  4'd0,  16'sh0000, ANY, 16'sh0000, 1'b0},
    '{ITEM, REQ_RD_C,    4'd0,  4'd0,  16'sh0000, CHK, 16'sh7fff, 1'b1},
    '{CFG,  REG_ROWS_M,  4'd0,  4'd0,  16'sh0000, ANY, 16'sh0000, 1'b0},
    '{ITEM, REQ_COMPUTE, 4'd0,  4'd0,  16'sh0000, ANY, 16'sh0000, 1'b0},
    '{ITEM, REQ_RD_C,    4'd0,  4'd0,  16'sh0000, CHK, 16'sh7fff, 1'b0}
  };

  logic               clk_i;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  mma_req_if req_if ();
  mma_rsp_if rsp_if ();

  matrix_multiply_accumulate u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_if),
    .rsp     (rsp_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // bench copy of the engine state
  logic signed [VAL_W-1:0] a_mat [GRID*GRID];
  logic signed [VAL_W-1:0] b_mat [GRID*GRID];
  logic signed [VAL_W-1:0] c_mat [GRID*GRID];
  bit                      a_loaded [GRID*GRID];
  bit                      b_loaded [GRID*GRID];
  bit                      sat_q;
  cfg_t                    cfg_q;

  rd_result_t  c_reads_expected [$];
  int unsigned items_taken;
  int unsigned mismatches;
  int unsigned busy_cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout, %0d reads still outstanding", $time, c_reads_expected.size());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic int unsigned eff_dim(logic [DIMCFG_W-1:0] d);
    return (d > GRID) ? GRID : int'(d);
  endfunction

  function automatic void run_gemm();
    int unsigned m, k, n;
    longint      acc;
    longint      v;
    m = eff_dim(cfg_q.rows_m);
    k = eff_dim(cfg_q.inner_k);
    n = eff_dim(cfg_q.cols_n);
    sat_q = 1'b0;
    for (int r = 0; r < m; r++) begin
      for (int c = 0; c < n; c++) begin
        acc = 0;
        for (int j = 0; j < k; j++) begin
          acc += longint'(a_mat[r*GRID+j]) * longint'(b_mat[j*GRID+c]);
        end
        // arithmetic shifts on signed values round toward minus infinity
        v = ((longint'(cfg_q.alpha_scale) * acc) >>> 16) +
            ((longint'(cfg_q.beta_scale) * longint'(c_mat[r*GRID+c])) >>> 8);
        if (v > 32767) begin
          v = 32767;
          sat_q = 1'b1;
        end
        if (v < -32768) begin
          v = -32768;
          sat_q = 1'b1;
        end
        c_mat[r*GRID+c] = v[VAL_W-1:0];
      end
    end
    busy_cycles = m * n * (k + 8);
  endfunction

  function automatic bit gemm_apply(input gemm_req_t it, output rd_result_t res);
    int unsigned idx;
    idx = {it.row, it.col};
    res = '0;
    case (it.req)
      REQ_WR_A: begin
        a_mat[idx] = it.value;
        a_loaded[idx] = 1'b1;
      end
      REQ_WR_B: begin
        b_mat[idx] = it.value;
        b_loaded[idx] = 1'b1;
      end
      REQ_WR_C: c_mat[idx] = it.value;
      REQ_COMPUTE: run_gemm();
      REQ_RD_C: begin
        res.value = c_mat[idx];
        res.sat = sat_q;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic int unsigned req_idle_pct();
    if (items_taken < 220) return 36;
    if (items_taken < 440) return 78;
    return 0;
  endfunction

  function automatic int unsigned rsp_idle_pct();
    if (items_taken < 220) return 78;
    if (items_taken < 440) return 36;
    return 0;
  endfunction

  function automatic logic signed [VAL_W-1:0] pick_value();
    logic [31:0] r;
    r = $urandom();
    case ($urandom_range(0, 7))
      0, 1: return VAL_W'($urandom_range(0, 1023) - 512);
      2: begin
        case ($urandom_range(0, 3))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      default: return r[VAL_W-1:0];
    endcase
  endfunction

  // mostly inside the active shape, now and then anywhere
  function automatic logic [IDX_W-1:0] pick_index(int unsigned lim);
    if (lim == 0 || $urandom_range(0, 99) < 15) return IDX_W'($urandom_range(0, GRID-1));
    return IDX_W'($urandom_range(0, lim-1));
  endfunction

  // first A or B entry that the next compute would read before it is loaded
  function automatic bit find_missing(output gemm_req_t fill);
    int unsigned m, k, n;
    m = eff_dim(cfg_q.rows_m);
    k = eff_dim(cfg_q.inner_k);
    n = eff_dim(cfg_q.cols_n);
    fill = '0;
    fill.value = pick_value();
    if (m == 0 || n == 0) return 1'b0;
    for (int j = 0; j < k; j++) begin
      for (int r = 0; r < m; r++) begin
        if (!a_loaded[r*GRID+j]) begin
          fill.req = REQ_WR_A;
          fill.row = IDX_W'(r);
          fill.col = IDX_W'(j);
          return 1'b1;
        end
      end
      for (int c = 0; c < n; c++) begin
        if (!b_loaded[j*GRID+c]) begin
          fill.req = REQ_WR_B;
          fill.row = IDX_W'(j);
          fill.col = IDX_W'(c);
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic gemm_req_t pick_item(int unsigned cmp_pct);
    gemm_req_t   it;
    gemm_req_t   fill;
    int unsigned roll, m, k, n;
    m = eff_dim(cfg_q.rows_m);
    k = eff_dim(cfg_q.inner_k);
    n = eff_dim(cfg_q.cols_n);
    roll = $urandom_range(0, 99);
    it.value = pick_value();
    it.row = IDX_W'($urandom_range(0, GRID-1));
    it.col = IDX_W'($urandom_range(0, GRID-1));
    if (roll < 4) begin
      it.req = REQ_W'($urandom_range(REQ_RSVD_5, REQ_RSVD_7));
    end else if (roll < 4 + cmp_pct) begin
      it.req = REQ_COMPUTE;
      if (find_missing(fill)) it = fill;
    end else if (roll < 26 + cmp_pct) begin
      it.req = REQ_RD_C;
      it.row = pick_index(m);
      it.col = pick_index(n);
    end else begin
      case ($urandom_range(0, 2))
        0: begin
          it.req = REQ_WR_A;
          it.row = pick_index(m);
          it.col = pick_index(k);
        end
        1: begin
          it.req = REQ_WR_B;
          it.row = pick_index(k);
          it.col = pick_index(n);
        end
        default: begin
          it.req = REQ_WR_C;
          it.row = pick_index(m);
          it.col = pick_index(n);
        end
      endcase
    end
    return it;
  endfunction

  task automatic offer_item(input gemm_req_t it, input bit typed, input rd_result_t typed_res);
    rd_result_t res;
    while ($urandom_range(0, 99) < req_idle_pct()) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.req_type      <= it.req;
    req_if.row_index     <= it.row;
    req_if.col_index     <= it.col;
    req_if.element_value <= it.value;
    @(negedge clk_i);
    while (!req_if.ready) @(negedge clk_i);
    @(posedge clk_i);
    items_taken++;
    if (gemm_apply(it, res)) c_reads_expected = {c_reads_expected, typed ? typed_res : res};
  endtask

  // wait until every read is back and a compute in flight has surely ended
  task automatic settle_block();
    req_if.valid <= 1'b0;
    @(negedge clk_i);
    while (c_reads_expected.size() != 0) @(negedge clk_i);
    repeat (busy_cycles + 32) @(posedge clk_i);
    busy_cycles = 0;
  endtask

  task automatic write_reg(input logic [REGIDX_W-1:0] idx, input logic [PDATA_W-1:0] data);
    settle_block();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    while (!pready) @(negedge clk_i);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_ROWS_M:  cfg_q.rows_m = data[DIMCFG_W-1:0];
      REG_INNER_K: cfg_q.inner_k = data[DIMCFG_W-1:0];
      REG_COLS_N:  cfg_q.cols_n = data[DIMCFG_W-1:0];
      REG_ALPHA:   cfg_q.alpha_scale = data[SCALE_W-1:0];
      REG_BETA:    cfg_q.beta_scale = data[SCALE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic run_phase(input logic [DIMCFG_W-1:0] m, input logic [DIMCFG_W-1:0] k,
                           input logic [DIMCFG_W-1:0] n, input logic signed [SCALE_W-1:0] alpha,
                           input logic signed [SCALE_W-1:0] beta, input int unsigned n_items,
                           input int unsigned cmp_pct);
    gemm_req_t   it;
    int unsigned counted;
    write_reg(REG_ROWS_M, PDATA_W'(m));
    write_reg(REG_INNER_K, PDATA_W'(k));
    write_reg(REG_COLS_N, PDATA_W'(n));
    write_reg(REG_ALPHA, PDATA_W'(alpha));
    write_reg(REG_BETA, PDATA_W'(beta));
    counted = 0;
    while (counted < n_items) begin
      it = pick_item(cmp_pct);
      offer_item(it, 1'b0, '0);
      // ignored codes do not count
      if (it.req < REQ_RSVD_5) counted++;
    end
  endtask

  initial begin : stimulus
    gemm_req_t  it;
    rd_result_t typed_res;
    req_if.valid         = 1'b0;
    req_if.req_type      = REQ_WR_A;
    req_if.row_index     = '0;
    req_if.col_index     = '0;
    req_if.element_value = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    rst_ni      = 1'b0;
    items_taken = 0;
    mismatches  = 0;
    sat_q       = 1'b0;
    busy_cycles = GRID * GRID;  // clearing pass of C after reset
    cfg_q.rows_m      = 5'd16;
    cfg_q.inner_k     = 5'd16;
    cfg_q.cols_n      = 5'd16;
    cfg_q.alpha_scale = 16'sh0100;
    cfg_q.beta_scale  = 16'sh0000;
    for (int i = 0; i < GRID*GRID; i++) begin
      a_mat[i]    = '0;
      b_mat[i]    = '0;
      c_mat[i]    = '0;
      a_loaded[i] = 1'b0;
      b_loaded[i] = 1'b0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_tbl[i].cfg_row) begin
        write_reg(dir_tbl[i].code, PDATA_W'(dir_tbl[i].value));
      end else begin
        it.req   = dir_tbl[i].code;
        it.row   = dir_tbl[i].row;
        it.col   = dir_tbl[i].col;
        it.value = dir_tbl[i].value;
        typed_res.value = dir_tbl[i].exp_value;
        typed_res.sat   = dir_tbl[i].exp_sat;
        offer_item(it, dir_tbl[i].typed, typed_res);
      end
    end

    run_phase(5'd2, 5'd3, 5'd2, 16'sh0100, 16'sh0000, 100, 8);
    run_phase(5'd4, 5'd4, 5'd4, SCALE_W'($urandom()), SCALE_W'($urandom()), 100, 8);
    run_phase(5'd1, 5'd31, 5'd1, 16'sh8000, 16'sh7fff, 90, 10);
    run_phase(5'd31, 5'd2, 5'd31, 16'sh0001, 16'sh8000, 90, 3);
    run_phase(5'd3, 5'd0, 5'd5, 16'sh7fff, 16'sh0080, 70, 10);
    run_phase(5'd0, 5'd2, 5'd4, 16'shff00, 16'sh0100, 50, 10);
    run_phase(5'd16, 5'd4, 5'd16, SCALE_W'($urandom_range(0, 1023) - 512),
              SCALE_W'($urandom()), 100, 3);

    settle_block();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : rsp_drive
    bit held;
    held = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      // one long stall so the output register fills and the request side backs up
      if (!held && items_taken >= HOLD_AT) begin
        held = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      rsp_if.ready <= ($urandom_range(0, 99) >= rsp_idle_pct());
    end
  end

  always @(negedge clk_i) begin : rsp_check
    rd_result_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (c_reads_expected.size() == 0) begin
        $display("%0t: unexpected read item, expected none, got value %0d sat %0b",
                 $time, rsp_if.read_value, rsp_if.saturated);
        mismatches++;
      end else begin
        want = c_reads_expected.pop_front();
        if (rsp_if.read_value !== want.value) begin
          $display("%0t: read_value mismatch, expected %0d, got %0d",
                   $time, want.value, rsp_if.read_value);
          mismatches++;
        end
        if (rsp_if.saturated !== want.sat) begin
          $display("%0t: saturated mismatch, expected %0b, got %0b",
                   $time, want.sat, rsp_if.saturated);
          mismatches++;
        end
      end
    end
  end

endmodule

`default_nettype wire
